// ----- hdl/ppid_pkg.sv -----
// Shared widths, register codes, reset values and the threshold band lookup.
package ppid_pkg;

  localparam int ERROR_BITS_DEF     = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int SETPOINT_W = 13;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 20;
  localparam int DRIVE_W    = 16;
  localparam int THRESH_W   = 10;
  localparam int INTEG_W    = LIMIT_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [LIMIT_W-1:0]        LIMIT_RESET     = LIMIT_W'(1000);
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX_RESET = 16'sh7FFF;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN_RESET = -16'sh8000;

  // Setpoint band edges
  localparam int SP_ZERO     = 0;
  localparam int SP_LOW_EDGE = 450;
  localparam int SP_MID_EDGE = 550;
  localparam int SP_MID_LO   = 650;
  localparam int SP_UPPER    = 750;
  localparam int SP_MID_HI   = 850;

  // Thresholds picked by the bands
  localparam logic [THRESH_W-1:0] THR_MID   = THRESH_W'(750);
  localparam logic [THRESH_W-1:0] THR_HIGH  = THRESH_W'(400);
  localparam logic [THRESH_W-1:0] THR_UPMID = THRESH_W'(550);
  localparam logic [THRESH_W-1:0] THR_LOW   = THRESH_W'(450);
  localparam logic [THRESH_W-1:0] THR_GAP   = THRESH_W'(510);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT  = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_LIMIT     = 3'd4,
    REG_DRIVE_MAX = 3'd5,
    REG_DRIVE_MIN = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                hit;
    logic [THRESH_W-1:0] value;
  } thresh_sel_t;

  // Band lookup; no hit means the threshold keeps its last value.
  function automatic thresh_sel_t band_lookup(input logic signed [SETPOINT_W-1:0] sp);
    int          d;
    thresh_sel_t sel;
    d         = int'(sp);
    sel.hit   = 1'b1;
    sel.value = THR_MID;
    if (d >= SP_MID_LO && d <= SP_MID_HI) begin
      sel.value = THR_MID;
    end else if (d > SP_MID_HI) begin
      sel.value = THR_HIGH;
    end else if (d > SP_LOW_EDGE && d < SP_MID_EDGE) begin
      sel.value = THR_UPMID;
    end else if (d > SP_ZERO && d < SP_LOW_EDGE) begin
      sel.value = THR_LOW;
    end else if (d > SP_MID_EDGE && d < SP_UPPER) begin
      sel.value = THR_GAP;
    end else begin
      sel.hit = 1'b0;
    end
    return sel;
  endfunction

endpackage

// ----- hdl/ppid_front.sv -----
// Front stage: threshold band, conditional integration with clamp, derivative.
module ppid_front import ppid_pkg::*; #(
  parameter int ERROR_BITS = ERROR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ERROR_BITS-1:0] error_sample,
  input  logic signed [SETPOINT_W-1:0] setpoint,
  input  logic        [LIMIT_W-1:0]    integral_limit,
  output logic                         s1_valid,
  input  logic                         s1_ready,
  output logic signed [ERROR_BITS-1:0] s1_error,
  output logic signed [INTEG_W-1:0]    s1_integ,
  output logic signed [ERROR_BITS:0]   s1_deriv
);

  localparam int CMP_W = (ERROR_BITS > THRESH_W + 1) ? ERROR_BITS : THRESH_W + 1;
  localparam int SUM_W = ((ERROR_BITS > INTEG_W) ? ERROR_BITS : INTEG_W) + 1;

  logic        [THRESH_W-1:0]   threshold;
  logic        [THRESH_W-1:0]   threshold_next;
  logic signed [INTEG_W-1:0]    integral_sum;
  logic signed [INTEG_W-1:0]    integral_sum_next;
  logic signed [ERROR_BITS-1:0] previous_error;
  thresh_sel_t                  band;
  logic signed [CMP_W-1:0]      err_cmp;
  logic signed [CMP_W-1:0]      thr_cmp;
  logic signed [SUM_W-1:0]      sum_raw;
  logic signed [SUM_W-1:0]      lim_pos;
  logic signed [SUM_W-1:0]      lim_neg;
  logic                         accept;

  assign in_ready = !s1_valid || s1_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    band           = band_lookup(setpoint);
    threshold_next = band.hit ? band.value : threshold;
    err_cmp        = CMP_W'(error_sample);
    thr_cmp        = CMP_W'($signed({1'b0, threshold_next}));
    sum_raw        = SUM_W'(integral_sum);
    if (err_cmp < thr_cmp) begin
      sum_raw = SUM_W'(integral_sum) + SUM_W'(error_sample);
    end
    lim_pos = SUM_W'($signed({1'b0, integral_limit}));
    lim_neg = -lim_pos;
    priority if (sum_raw > lim_pos) begin
      integral_sum_next = INTEG_W'(lim_pos);
    end else if (sum_raw < lim_neg) begin
      integral_sum_next = INTEG_W'(lim_neg);
    end else begin
      integral_sum_next = INTEG_W'(sum_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= '0;
      integral_sum   <= '0;
      previous_error <= '0;
      s1_valid       <= 1'b0;
    end else begin
      if (accept) begin
        threshold      <= threshold_next;
        integral_sum   <= integral_sum_next;
        previous_error <= error_sample;
        s1_valid       <= 1'b1;
      end else if (s1_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_error <= error_sample;
      s1_integ <= integral_sum_next;
      s1_deriv <= (ERROR_BITS+1)'(error_sample) - (ERROR_BITS+1)'(previous_error);
    end
  end

endmodule

// ----- hdl/ppid_mult.sv -----
// Product stage: three gain multiplies, each into its own register.
module ppid_mult import ppid_pkg::*; #(
  parameter int ERROR_BITS = ERROR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s1_valid,
  output logic                                s1_ready,
  input  logic signed [ERROR_BITS-1:0]        s1_error,
  input  logic signed [INTEG_W-1:0]           s1_integ,
  input  logic signed [ERROR_BITS:0]          s1_deriv,
  input  logic signed [GAIN_W-1:0]            gain_p,
  input  logic signed [GAIN_W-1:0]            gain_i,
  input  logic signed [GAIN_W-1:0]            gain_d,
  output logic                                s2_valid,
  input  logic                                s2_ready,
  output logic signed [GAIN_W+ERROR_BITS-1:0] s2_prod_p,
  output logic signed [GAIN_W+INTEG_W-1:0]    s2_prod_i,
  output logic signed [GAIN_W+ERROR_BITS:0]   s2_prod_d
);

  logic advance;

  assign s1_ready = !s2_valid || s2_ready;
  assign advance  = s1_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= 1'b1;
    end else if (s2_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_prod_p <= gain_p * s1_error;
      s2_prod_i <= gain_i * s1_integ;
      s2_prod_d <= gain_d * s1_deriv;
    end
  end

endmodule

// ----- hdl/ppid_out.sv -----
// Output stage: sum, scale toward zero, clamp to max then min, result register.
module ppid_out import ppid_pkg::*; #(
  parameter int ERROR_BITS     = ERROR_BITS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s2_valid,
  output logic                                s2_ready,
  input  logic signed [GAIN_W+ERROR_BITS-1:0] s2_prod_p,
  input  logic signed [GAIN_W+INTEG_W-1:0]    s2_prod_i,
  input  logic signed [GAIN_W+ERROR_BITS:0]   s2_prod_d,
  input  logic signed [DRIVE_W-1:0]           drive_max,
  input  logic signed [DRIVE_W-1:0]           drive_min,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [DRIVE_W-1:0]           drive
);

  localparam int D_W   = GAIN_W + ERROR_BITS + 1;
  localparam int I_W   = GAIN_W + INTEG_W;
  localparam int ACC_W = ((D_W > I_W) ? D_W : I_W) + 2;
  localparam logic [ACC_W-1:0] BIAS = (ACC_W'(1) << GAIN_FRAC_BITS) - ACC_W'(1);

  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   biased;
  logic signed [ACC_W-1:0]   scaled;
  logic signed [ACC_W-1:0]   hi_lim;
  logic signed [ACC_W-1:0]   lo_lim;
  logic signed [ACC_W-1:0]   clamped;
  logic                      advance;

  assign s2_ready = !out_valid || out_ready;
  assign advance  = s2_valid && s2_ready;

  always_comb begin
    acc    = ACC_W'(s2_prod_p) + ACC_W'(s2_prod_i) + ACC_W'(s2_prod_d);
    // Bias negative sums so the arithmetic shift truncates toward zero
    biased = acc[ACC_W-1] ? acc + $signed(BIAS) : acc;
    scaled = biased >>> GAIN_FRAC_BITS;
    hi_lim = ACC_W'(drive_max);
    lo_lim = ACC_W'(drive_min);
    clamped = (scaled > hi_lim) ? hi_lim : scaled;
    if (clamped < lo_lim) begin
      clamped = lo_lim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive <= DRIVE_W'(clamped);
    end
  end

endmodule

// ----- hdl/positional_pid_controller_unit.sv -----
// Top level of the positional PID controller: configuration registers and stage chain.
//
//   channel   | handshake              | word
//   ----------+------------------------+-------------------------------------
//   input     | in_valid / in_ready    | error_sample, ERROR_BITS signed
//   output    | out_valid / out_ready  | drive, 16 bit signed
//   config    | cfg_write (no wait)    | cfg_index selects, cfg_data carries
//
// Three register stages: integration/derivative, gain products, sum/scale/clamp.
// Each stage registers a word in turn before out_valid shows it; without a stall one
// word a cycle streams through, the integral loop closing inside the first stage.
// Each stage holds while the stage after it is full and not draining, so a stall
// on out_ready backs up stage by stage; in_ready drops only once all are full.
// Synchronous reset clears the integral, previous error, threshold, stage valids
// and all configuration registers to their reset values.
module positional_pid_controller_unit import ppid_pkg::*; #(
  parameter int ERROR_BITS     = ERROR_BITS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ERROR_BITS-1:0] error_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DRIVE_W-1:0]    drive
);

  // Configuration registers
  logic signed [SETPOINT_W-1:0] setpoint;
  logic signed [GAIN_W-1:0]     gain_p;
  logic signed [GAIN_W-1:0]     gain_i;
  logic signed [GAIN_W-1:0]     gain_d;
  logic        [LIMIT_W-1:0]    integral_limit;
  logic signed [DRIVE_W-1:0]    drive_max;
  logic signed [DRIVE_W-1:0]    drive_min;

  // Stage links
  logic                                s1_valid;
  logic                                s1_ready;
  logic signed [ERROR_BITS-1:0]        s1_error;
  logic signed [INTEG_W-1:0]           s1_integ;
  logic signed [ERROR_BITS:0]          s1_deriv;
  logic                                s2_valid;
  logic                                s2_ready;
  logic signed [GAIN_W+ERROR_BITS-1:0] s2_prod_p;
  logic signed [GAIN_W+INTEG_W-1:0]    s2_prod_i;
  logic signed [GAIN_W+ERROR_BITS:0]   s2_prod_d;

  // Take a register write; drop writes to indexes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint       <= '0;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_limit <= LIMIT_RESET;
      drive_max      <= DRIVE_MAX_RESET;
      drive_min      <= DRIVE_MIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SETPOINT:  setpoint       <= cfg_data[SETPOINT_W-1:0];
        REG_GAIN_P:    gain_p         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:    gain_i         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:    gain_d         <= cfg_data[GAIN_W-1:0];
        REG_LIMIT:     integral_limit <= cfg_data[LIMIT_W-1:0];
        REG_DRIVE_MAX: drive_max      <= cfg_data[DRIVE_W-1:0];
        REG_DRIVE_MIN: drive_min      <= cfg_data[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Integrate, keep the threshold and previous error, form the derivative
  ppid_front #(
    .ERROR_BITS(ERROR_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .error_sample   (error_sample),
    .setpoint       (setpoint),
    .integral_limit (integral_limit),
    .s1_valid       (s1_valid),
    .s1_ready       (s1_ready),
    .s1_error       (s1_error),
    .s1_integ       (s1_integ),
    .s1_deriv       (s1_deriv)
  );

  // Multiply by the three gains
  ppid_mult #(
    .ERROR_BITS(ERROR_BITS)
  ) u_mult (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_error  (s1_error),
    .s1_integ  (s1_integ),
    .s1_deriv  (s1_deriv),
    .gain_p    (gain_p),
    .gain_i    (gain_i),
    .gain_d    (gain_d),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2_prod_p (s2_prod_p),
    .s2_prod_i (s2_prod_i),
    .s2_prod_d (s2_prod_d)
  );

  // Sum, scale, clamp and hold the result word
  ppid_out #(
    .ERROR_BITS     (ERROR_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2_prod_p (s2_prod_p),
    .s2_prod_i (s2_prod_i),
    .s2_prod_d (s2_prod_d),
    .drive_max (drive_max),
    .drive_min (drive_min),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive)
  );

endmodule
